[src/segregated_pool_block_allocator_macros.svh]
// Assertion macros for the segregated pool block allocator
`ifndef SEGREGATED_POOL_BLOCK_ALLOCATOR_MACROS_SVH
`define SEGREGATED_POOL_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SPBA_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define SPBA_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define SPBA_ASSERT_IMPL(label, clk, rst_n, a, c)
`define SPBA_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

[src/spba_pkg.sv]
// ----------------------------------------------------------------------------
// spba_pkg
// Types and constants shared by the pool allocator modules.
// ----------------------------------------------------------------------------
package spba_pkg;
    localparam int NUM_BUCKETS_DEF = 4;
    localparam int MAX_BLOCKS_DEF  = 256;
    localparam int BLOCK_ALIGN_DEF = 16;
    localparam int SIZE_W  = 21;
    localparam int COUNT_W = 9;

    typedef enum logic [1:0] {
        CMD_INIT    = 2'd0,
        CMD_ALLOC   = 2'd1,
        CMD_FREE    = 2'd2,
        CMD_REALLOC = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_BADADDR = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_LOC,
        S_DIV,
        S_DECIDE,
        S_ASCAN,
        S_ARD,
        S_AMUL,
        S_AFIN,
        S_PUSH,
        S_OUT
    } t_state;

    // divider handshake
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;
endpackage

[src/segregated_pool_block_allocator.sv]
// Free and realloc locate the block through the serial divider; alloc does not use it.
// Init walks every block once, writing the links of each bucket in turn.
// One item at a time; the next item is accepted the cycle after the result is taken.
// Synchronous active-low reset: config registers to defaults, all free lists empty.
// ----------------------------------------------------------------------------
// segregated_pool_block_allocator
// Segregated free-list pool allocator with APB register port.
// ----------------------------------------------------------------------------
`include "segregated_pool_block_allocator_macros.svh"
module segregated_pool_block_allocator
    import spba_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
    parameter int BLOCK_ALIGN = BLOCK_ALIGN_DEF
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_block_offset,
    input  logic [31:0] i_request_size,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result_offset,
    output logic [1:0]  o_status,
    output logic [1:0]  o_bucket_index,
    output logic        o_moved
);
    localparam int BW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int JW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW  = $clog2(MAX_BLOCKS + 1);
    localparam int AW  = BW + JW;
    localparam int DEP = NUM_BUCKETS * MAX_BLOCKS;
    localparam int ALW = (BLOCK_ALIGN > 1) ? $clog2(BLOCK_ALIGN) : 1;
    localparam int NREG = 4;

    // ---------------- config registers ----------------
    logic [SIZE_W-1:0]  r_size  [NREG];
    logic [COUNT_W-1:0] r_count [NREG];
    logic [2:0] w_ridx;
    assign w_ridx = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NREG; k++) begin
                r_size[k]  <= SIZE_W'(16 << (2 * k));
                r_count[k] <= COUNT_W'(64);
            end
        end else if (psel && penable && pwrite) begin
            if (!w_ridx[2]) r_size[w_ridx[1:0]]  <= pwdata[SIZE_W-1:0];
            else            r_count[w_ridx[1:0]] <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        if (!w_ridx[2]) prdata = {11'd0, r_size[w_ridx[1:0]]};
        else            prdata = {23'd0, r_count[w_ridx[1:0]]};
    end

    // per-bucket size, clamped count, aligned size (constant-index logic)
    logic [SIZE_W-1:0] w_bsz  [NUM_BUCKETS];
    logic [CW-1:0]     w_bcnt [NUM_BUCKETS];
    logic [29:0]       w_asz  [NUM_BUCKETS];
    always_comb begin
        for (int b = 0; b < NUM_BUCKETS; b++) begin
            if (b < NREG) begin
                w_bsz[b] = r_size[b];
                w_bcnt[b] = (32'(r_count[b]) > MAX_BLOCKS) ? CW'(MAX_BLOCKS)
                                                           : CW'(r_count[b]);
            end else begin
                w_bsz[b] = '0; w_bcnt[b] = '0;
            end
            w_asz[b] = 30'(((32'(w_bsz[b]) + BLOCK_ALIGN - 1) >> ALW) << ALW);
            if (BLOCK_ALIGN == 1) w_asz[b] = 30'(w_bsz[b]);
        end
    end

    // ---------------- datapath state ----------------
    t_state r_state, n_state;
    logic [BW-1:0]  r_b, n_b;          // scan bucket
    logic [BW-1:0]  r_lb, n_lb;        // located bucket
    logic [JW-1:0]  r_lj, n_lj;
    logic [CW-1:0]  r_j, n_j;          // init counter
    logic [39:0]    r_start, n_start;  // running bucket start
    logic [1:0]     r_cmd, n_cmd;
    logic [31:0]    r_boff, n_boff;
    logic [31:0]    r_req, n_req;
    logic [NUM_BUCKETS-1:0] r_hv, n_hv;
    logic [JW-1:0]  r_hi [NUM_BUCKETS];
    logic [JW-1:0]  n_hi [NUM_BUCKETS];
    logic [39:0]    r_prod, n_prod;
    logic           r_ov, n_ov;
    logic [31:0]    r_roff, n_roff;
    logic [1:0]     r_st, n_st;
    logic [BW-1:0]  r_bidx, n_bidx;
    logic           r_mv, n_mv;

    // link memory: valid bit + index
    logic [JW:0]    r_mem [DEP];
    logic [JW:0]    r_rd;
    logic           w_we, w_re;
    logic [AW-1:0]  w_wa, w_ra;
    logic [JW:0]    w_wd;
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        if (w_re) r_rd <= r_mem[w_ra];
    end

    // divider, loaded from the bucket that the locate step is looking at
    logic        w_dstart;
    t_div_stat   w_dst;
    logic [39:0] w_quo, w_rem;
    spba_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(40'(r_boff) - r_start), .i_den(w_asz[r_b]),
        .o_stat(w_dst), .o_quo(w_quo), .o_rem(w_rem)
    );

    logic [39:0] w_span;
    assign w_span = 40'(w_bcnt[r_b]) * 40'(w_asz[r_b]);

    always_comb begin
        n_state = r_state; n_b = r_b; n_lb = r_lb; n_lj = r_lj; n_j = r_j;
        n_start = r_start; n_cmd = r_cmd; n_boff = r_boff;
        n_req = r_req; n_hv = r_hv; n_hi = r_hi; n_prod = r_prod; n_ov = r_ov;
        n_roff = r_roff; n_st = r_st; n_bidx = r_bidx; n_mv = r_mv;
        w_we = 1'b0; w_re = 1'b0; w_wa = '0; w_ra = '0; w_wd = '0; w_dstart = 1'b0;
        o_ready = (r_state == S_IDLE) && !r_ov;
        unique case (r_state)
            S_IDLE: if (i_valid && o_ready) begin
                n_cmd = i_cmd; n_boff = i_block_offset; n_req = i_request_size;
                n_b = '0; n_j = '0; n_start = '0;
                n_roff = '0; n_st = ST_OK; n_bidx = '0; n_mv = 1'b0;
                unique case (t_cmd'(i_cmd))
                    CMD_INIT:  n_state = S_INIT;
                    CMD_ALLOC: n_state = S_ASCAN;
                    default:   n_state = S_LOC;
                endcase
            end
            // write one link per cycle, bucket by bucket
            S_INIT: begin
                if (r_j == '0) begin
                    n_hv[r_b] = (w_bcnt[r_b] != '0);
                    n_hi[r_b] = '0;
                end
                if (r_j < w_bcnt[r_b]) begin
                    w_we = 1'b1;
                    w_wa = AW'({r_b, r_j[JW-1:0]});
                    w_wd = {(r_j + CW'(1) < w_bcnt[r_b]),
                            (r_j + CW'(1) < w_bcnt[r_b]) ? JW'(r_j + CW'(1)) : JW'(0)};
                    n_j = r_j + CW'(1);
                end else begin
                    n_j = '0;
                    if (32'(r_b) == NUM_BUCKETS - 1) n_state = S_OUT;
                    else n_b = r_b + BW'(1);
                end
            end
            // find bucket containing offset, one bucket per cycle
            S_LOC: begin
                if (w_asz[r_b] != '0 && 40'(r_boff) >= r_start
                        && 40'(r_boff) < r_start + w_span) begin
                    n_lb = r_b;
                    n_state = S_DIV;
                    w_dstart = 1'b1;
                end else if (32'(r_b) == NUM_BUCKETS - 1) begin
                    n_st = ST_BADADDR; n_state = S_OUT;
                end else begin
                    n_start = r_start + w_span; n_b = r_b + BW'(1);
                end
            end
            S_DIV: if (w_dst.done) begin
                if (w_rem != '0) begin
                    n_st = ST_BADADDR; n_state = S_OUT;
                end else begin
                    n_lj = JW'(w_quo);
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_cmd == CMD_FREE || r_req == '0) begin
                    n_bidx = r_lb; n_state = S_PUSH;
                end else if ((r_lb == '0 || 32'(w_bsz[r_lb - BW'(1)]) < r_req)
                             && r_req <= 32'(w_bsz[r_lb])) begin
                    n_roff = r_boff; n_bidx = r_lb; n_state = S_OUT;
                end else begin
                    n_b = '0; n_start = '0; n_state = S_ASCAN;
                end
            end
            // scan buckets for first fit with a free head
            S_ASCAN: begin
                if (32'(w_bsz[r_b]) >= r_req && r_hv[r_b]) begin
                    w_re = 1'b1;
                    w_ra = AW'({r_b, r_hi[r_b]});
                    n_state = S_ARD;
                end else if (32'(r_b) == NUM_BUCKETS - 1) begin
                    n_st = ST_NOFIT; n_state = S_OUT;
                end else begin
                    n_start = r_start + w_span; n_b = r_b + BW'(1);
                end
            end
            S_ARD: begin
                n_prod = 40'(r_hi[r_b]) * 40'(w_asz[r_b]);
                n_hv[r_b] = r_rd[JW];
                n_hi[r_b] = r_rd[JW-1:0];
                n_state = S_AMUL;
            end
            S_AMUL: begin
                n_roff = 32'(r_start + r_prod);
                n_bidx = r_b;
                if (r_cmd == CMD_REALLOC) begin
                    n_mv = 1'b1; n_state = S_PUSH;
                end else n_state = S_OUT;
            end
            S_PUSH: begin
                w_we = 1'b1;
                w_wa = AW'({r_lb, r_lj});
                w_wd = {r_hv[r_lb], r_hi[r_lb]};
                n_hv[r_lb] = 1'b1;
                n_hi[r_lb] = r_lj;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_ov = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_ov && i_ready) n_ov = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ov <= 1'b0; r_hv <= '0;
        end else begin
            r_state <= n_state; r_ov <= n_ov; r_hv <= n_hv;
        end
        r_b <= n_b; r_lb <= n_lb; r_lj <= n_lj; r_j <= n_j; r_start <= n_start;
        r_cmd <= n_cmd; r_boff <= n_boff; r_req <= n_req;
        r_hi <= n_hi; r_prod <= n_prod; r_roff <= n_roff; r_st <= n_st;
        r_bidx <= n_bidx; r_mv <= n_mv;
    end

    assign o_valid = r_ov;
    assign o_result_offset = (r_st == ST_OK) ? r_roff : 32'd0;
    assign o_status = r_st;
    assign o_bucket_index = (r_st == ST_OK) ? 2'(r_bidx) : 2'd0;
    assign o_moved = (r_st == ST_OK) && r_mv;

    `SPBA_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == S_IDLE && !o_valid)
    `SPBA_ASSERT_IMPL(a_err_clean, i_clk, i_rst_n, o_valid && o_status != ST_OK, !o_moved)
    `SPBA_ASSERT_NEXT(a_out_next, i_clk, i_rst_n, r_state == S_OUT, o_valid)
    `SPBA_ASSERT_IMPL(a_div_wait, i_clk, i_rst_n, r_state == S_DIV && !w_dst.done, w_dst.busy)
endmodule

[src/spba_div.sv]
// ----------------------------------------------------------------------------
// spba_div
// Restoring divider, one quotient bit per cycle; quotient and remainder.
// ----------------------------------------------------------------------------
module spba_div
    import spba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [39:0] i_num,
    input  logic [29:0] i_den,
    output t_div_stat   o_stat,
    output logic [39:0] o_quo,
    output logic [39:0] o_rem
);
    logic [39:0] r_q, n_q;
    logic [39:0] r_r, n_r;
    logic [29:0] r_d, n_d;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [40:0] w_tr;

    // one shift-subtract step per cycle
    always_comb begin
        n_q = r_q; n_r = r_r; n_d = r_d; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        w_tr = {r_r, r_q[39]};
        if (i_start) begin
            n_q = i_num; n_r = '0; n_d = i_den; n_cnt = 6'd40; n_busy = 1'b1;
        end else if (r_busy) begin
            n_q = {r_q[38:0], 1'b0};
            if (w_tr >= {11'd0, r_d}) begin
                n_r = 40'(w_tr - {11'd0, r_d});
                n_q[0] = 1'b1;
            end else begin
                n_r = w_tr[39:0];
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_r <= n_r; r_d <= n_d;
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_quo  = r_q;
    assign o_rem  = r_r;
endmodule
